// ===== hdl/ps2mct_pkg.sv =====
// shared constants for the ps/2 mouse packet cursor tracker
// header bit positions, field widths, register indexes and reset values
// no dependencies
package ps2mct_pkg;

   localparam int COORD_BITS_DEFAULT = 10;

   localparam int BYTE_BITS      = 8;
   localparam int MOVE_BITS      = 9;
   localparam int BUTTON_BITS    = 3;
   localparam int LIMIT_BITS     = 10;
   localparam int CSR_INDEX_BITS = 2;

   // header byte layout
   localparam int HDR_VALID_BIT = 3;
   localparam int HDR_XSIGN_BIT = 4;
   localparam int HDR_YSIGN_BIT = 5;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_X_LIMIT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_Y_LIMIT = 2'd1;

   localparam logic [LIMIT_BITS-1:0] X_LIMIT_RESET = 10'd316;
   localparam logic [LIMIT_BITS-1:0] Y_LIMIT_RESET = 10'd236;

   localparam int CURSOR_X_RESET = 160;
   localparam int CURSOR_Y_RESET = 120;

   typedef logic signed [MOVE_BITS-1:0] move_type;

endpackage

// ===== hdl/ps2mct_clamp.sv =====
// one cursor axis: adds a signed movement and clamps to 0..limit
// the limit is saturated to the largest value a coordinate can hold
// depends on ps2mct_pkg
module ps2mct_clamp #(
   parameter int COORD_BITS = ps2mct_pkg::COORD_BITS_DEFAULT
) (
   input  logic [COORD_BITS-1:0]                 cur,
   input  ps2mct_pkg::move_type                  move,
   input  logic [ps2mct_pkg::LIMIT_BITS-1:0]     limit,
   output logic [COORD_BITS-1:0]                 nxt
);
   import ps2mct_pkg::*;

   localparam int SUM_BITS = COORD_BITS + 2;
   localparam int WIDE_BITS = 17;
   localparam logic [WIDE_BITS-1:0] CMAX = WIDE_BITS'((1 << COORD_BITS) - 1);

   logic [WIDE_BITS-1:0]       limit_wide;
   logic [COORD_BITS-1:0]      limit_sat;
   logic signed [SUM_BITS-1:0] sum;

   always_comb begin
      limit_wide = WIDE_BITS'(limit);
      if (limit_wide > CMAX) begin
         limit_sat = CMAX[COORD_BITS-1:0];
      end else begin
         limit_sat = limit_wide[COORD_BITS-1:0];
      end
   end

   assign sum = $signed({2'b00, cur}) + SUM_BITS'(move);

   always_comb begin
      if (sum[SUM_BITS-1] || (sum == '0)) begin
         nxt = '0;
      end else if (sum[SUM_BITS-2:0] >= {1'b0, limit_sat}) begin
         nxt = limit_sat;
      end else begin
         nxt = sum[COORD_BITS-1:0];
      end
   end

endmodule

// ===== hdl/ps2_mouse_packet_cursor_tracker_core.sv =====
// ps/2 mouse three-byte packet framer with a clamped cursor
// latency: a result appears in the cycle after the third byte of a packet is accepted
// throughput: one byte per cycle; input stalls only while a result waits under rsp_stall
// reset (synchronous): waits for a header, cursor at 160/120, limits 316/236
// the cursor update for one packet is a single add and clamp per axis
// depends on ps2mct_pkg and ps2mct_clamp
module ps2_mouse_packet_cursor_tracker_core #(
   parameter int COORD_BITS = ps2mct_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_write_en,
   input  logic [ps2mct_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [ps2mct_pkg::LIMIT_BITS-1:0]       csr_wdata,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [ps2mct_pkg::BYTE_BITS-1:0]        req_rx_byte,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output ps2mct_pkg::move_type                    rsp_move_x,
   output ps2mct_pkg::move_type                    rsp_move_y,
   output logic [ps2mct_pkg::BUTTON_BITS-1:0]      rsp_button_bits,
   output logic [COORD_BITS-1:0]                   rsp_pos_x,
   output logic [COORD_BITS-1:0]                   rsp_pos_y,
   output logic                                    rsp_left_pressed
);
   import ps2mct_pkg::*;

   localparam logic [1:0] PH_HDR = 2'd0;
   localparam logic [1:0] PH_X   = 2'd1;
   localparam logic [1:0] PH_Y   = 2'd2;

   logic [1:0]             phase_ff, phase_in;
   logic [BYTE_BITS-1:0]   header_ff, header_in;
   logic [BYTE_BITS-1:0]   xbyte_ff, xbyte_in;
   logic [COORD_BITS-1:0]  cursor_x_ff, cursor_x_in;
   logic [COORD_BITS-1:0]  cursor_y_ff, cursor_y_in;
   logic                   last_left_ff, last_left_in;
   logic [LIMIT_BITS-1:0]  x_limit_ff, x_limit_in;
   logic [LIMIT_BITS-1:0]  y_limit_ff, y_limit_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   move_type               move_x_ff, move_x_in;
   move_type               move_y_ff, move_y_in;
   logic [BUTTON_BITS-1:0] buttons_ff, buttons_in;
   logic [COORD_BITS-1:0]  pos_x_ff, pos_x_in;
   logic [COORD_BITS-1:0]  pos_y_ff, pos_y_in;
   logic                   pressed_ff, pressed_in;

   logic                   accept;
   move_type               mx, my;
   logic [COORD_BITS-1:0]  next_x, next_y;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // sign bit from the header on top of the raw byte
   assign mx = $signed({header_ff[HDR_XSIGN_BIT], xbyte_ff});
   assign my = $signed({header_ff[HDR_YSIGN_BIT], req_rx_byte});

   ps2mct_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_x (
      .cur   (cursor_x_ff),
      .move  (mx),
      .limit (x_limit_ff),
      .nxt   (next_x)
   );

   ps2mct_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_y (
      .cur   (cursor_y_ff),
      .move  (my),
      .limit (y_limit_ff),
      .nxt   (next_y)
   );

   always_comb begin
      x_limit_in = x_limit_ff;
      y_limit_in = y_limit_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_X_LIMIT: x_limit_in = csr_wdata;
            CSR_Y_LIMIT: y_limit_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      header_in    = header_ff;
      xbyte_in     = xbyte_ff;
      cursor_x_in  = cursor_x_ff;
      cursor_y_in  = cursor_y_ff;
      last_left_in = last_left_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      move_x_in    = move_x_ff;
      move_y_in    = move_y_ff;
      buttons_in   = buttons_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      pressed_in   = pressed_ff;
      if (accept) begin
         case (phase_ff)
            PH_X: begin
               xbyte_in = req_rx_byte;
               phase_in = PH_Y;
            end
            PH_Y: begin
               phase_in     = PH_HDR;
               cursor_x_in  = next_x;
               cursor_y_in  = next_y;
               last_left_in = header_ff[0];
               rsp_valid_in = 1'b1;
               move_x_in    = mx;
               move_y_in    = my;
               buttons_in   = header_ff[BUTTON_BITS-1:0];
               pos_x_in     = next_x;
               pos_y_in     = next_y;
               pressed_in   = header_ff[0] && !last_left_ff;
            end
            default: begin
               // hunt for a header: bytes without the always-one bit are dropped
               if (req_rx_byte[HDR_VALID_BIT]) begin
                  header_in = req_rx_byte;
                  phase_in  = PH_X;
               end else begin
                  phase_in = PH_HDR;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HDR;
         header_ff    <= '0;
         cursor_x_ff  <= COORD_BITS'(CURSOR_X_RESET);
         cursor_y_ff  <= COORD_BITS'(CURSOR_Y_RESET);
         last_left_ff <= 1'b0;
         x_limit_ff   <= X_LIMIT_RESET;
         y_limit_ff   <= Y_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         header_ff    <= header_in;
         cursor_x_ff  <= cursor_x_in;
         cursor_y_ff  <= cursor_y_in;
         last_left_ff <= last_left_in;
         x_limit_ff   <= x_limit_in;
         y_limit_ff   <= y_limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      xbyte_ff   <= xbyte_in;
      move_x_ff  <= move_x_in;
      move_y_ff  <= move_y_in;
      buttons_ff <= buttons_in;
      pos_x_ff   <= pos_x_in;
      pos_y_ff   <= pos_y_in;
      pressed_ff <= pressed_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_move_x       = move_x_ff;
   assign rsp_move_y       = move_y_ff;
   assign rsp_button_bits  = buttons_ff;
   assign rsp_pos_x        = pos_x_ff;
   assign rsp_pos_y        = pos_y_ff;
   assign rsp_left_pressed = pressed_ff;

endmodule

// ===== hdl/ps2mct_checker.sv =====
// port-level checks for the ps/2 mouse packet cursor tracker
// bound to ps2_mouse_packet_cursor_tracker_core; depends on ps2mct_pkg
module ps2mct_checker #(
   parameter int COORD_BITS = ps2mct_pkg::COORD_BITS_DEFAULT
) (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_valid,
   input logic                                    req_stall,
   input logic                                    rsp_valid,
   input logic                                    rsp_stall,
   input ps2mct_pkg::move_type                    rsp_move_x,
   input ps2mct_pkg::move_type                    rsp_move_y,
   input logic [ps2mct_pkg::BUTTON_BITS-1:0]      rsp_button_bits,
   input logic [COORD_BITS-1:0]                   rsp_pos_x,
   input logic [COORD_BITS-1:0]                   rsp_pos_y,
   input logic                                    rsp_left_pressed
);
   import ps2mct_pkg::*;

   // a waiting result beat keeps its positions and movements
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pos_x) && $stable(rsp_pos_y)
         && $stable(rsp_move_x) && $stable(rsp_move_y))
      else $error("stalled result beat changed");

   // input is held back only by a full, stalled result register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a pending result");

   // a new result beat always follows an accepted byte
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall))
      else $error("result beat without an accepted byte");

   // a left press flag needs the left button down in the same beat
   a_press_left: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_left_pressed |-> rsp_button_bits[0])
      else $error("left press flagged with left button up");

endmodule

bind ps2_mouse_packet_cursor_tracker_core ps2mct_checker #(
   .COORD_BITS(COORD_BITS)
) u_ps2mct_checker (.*);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the ps/2 mouse packet cursor tracker
// uses ps2mct_pkg and ps2_mouse_packet_cursor_tracker_core, nothing else
module tb;
   import ps2mct_pkg::*;

   localparam int COORD           = COORD_BITS_DEFAULT;
   localparam int DRAIN_CYCLES    = 4;
   localparam int IDLE_LIMIT      = 2000;
   localparam int ITEMS_PER_PHASE = 120;
   localparam int NUM_PHASES      = 7;
   localparam int LIMIT_MAX       = (1 << LIMIT_BITS) - 1;

   // indexes with no register behind them, writes must be ignored
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_3 = 2'd3;

   typedef enum logic [1:0] {WAIT_HEADER, WAIT_X, WAIT_Y} frame_phase_t;
   typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_mode_t;

   typedef struct packed {
      move_type                move_x;
      move_type                move_y;
      logic [BUTTON_BITS-1:0]  buttons;
      logic [COORD-1:0]        pos_x;
      logic [COORD-1:0]        pos_y;
      logic                    left_pressed;
   } packet_result_t;

   typedef struct packed {
      logic [BYTE_BITS-1:0] rx_byte;
      logic                 typed;
      packet_result_t       result;
   } stim_row_t;

   localparam packet_result_t NO_RESULT = '0;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_write_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [LIMIT_BITS-1:0]     csr_wdata = '0;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [BYTE_BITS-1:0]      req_rx_byte = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   move_type                  rsp_move_x;
   move_type                  rsp_move_y;
   logic [BUTTON_BITS-1:0]    rsp_button_bits;
   logic [COORD-1:0]          rsp_pos_x;
   logic [COORD-1:0]          rsp_pos_y;
   logic                      rsp_left_pressed;

   // predictor state
   frame_phase_t          frame_phase = WAIT_HEADER;
   logic [BYTE_BITS-1:0]  hdr_q = '0;
   logic [BYTE_BITS-1:0]  xdata_q = '0;
   logic [COORD-1:0]      cur_x = COORD'(CURSOR_X_RESET);
   logic [COORD-1:0]      cur_y = COORD'(CURSOR_Y_RESET);
   logic                  left_q = 1'b0;
   logic [LIMIT_BITS-1:0] lim_x = X_LIMIT_RESET;
   logic [LIMIT_BITS-1:0] lim_y = Y_LIMIT_RESET;

   packet_result_t expected_packets[$];
   stim_row_t      directed_rows[$];

   int error_count   = 0;
   int bytes_sent    = 0;
   int dropped_bytes = 0;
   int packets_seen  = 0;
   int settings_used = 0;
   int burst_left    = 0;
   int idle_cycles   = 0;

   stall_mode_t stall_mode = STALL_NONE;
   int          mode_left  = 0;
   int          stall_period = 2;
   int          stall_duty = 1;
   int          stall_tick = 0;

   ps2_mouse_packet_cursor_tracker_core #(
      .COORD_BITS(COORD)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_move_x       (rsp_move_x),
      .rsp_move_y       (rsp_move_y),
      .rsp_button_bits  (rsp_button_bits),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_left_pressed (rsp_left_pressed)
   );

   always #5 clock = ~clock;

   task automatic report_error(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic logic [COORD-1:0] clamp_axis(input logic [COORD-1:0] cur, input int mv,
                                                   input logic [LIMIT_BITS-1:0] limit);
      int sum;
      int lim;
      sum = int'(cur) + mv;
      lim = int'(limit);
      if (lim > (1 << COORD) - 1) lim = (1 << COORD) - 1;
      if (sum <= 0) return '0;
      if (sum >= lim) return COORD'(lim);
      return COORD'(sum);
   endfunction

   // advance the packet framer by one byte, returns 1 when a packet completes
   function automatic bit track_byte(input logic [BYTE_BITS-1:0] b, output packet_result_t r);
      move_type mx;
      move_type my;
      bit       produced;
      produced = 1'b0;
      r = '0;
      case (frame_phase)
         WAIT_X: begin
            xdata_q = b;
            frame_phase = WAIT_Y;
         end
         WAIT_Y: begin
            frame_phase = WAIT_HEADER;
            mx = {hdr_q[HDR_XSIGN_BIT], xdata_q};
            my = {hdr_q[HDR_YSIGN_BIT], b};
            cur_x = clamp_axis(cur_x, int'(mx), lim_x);
            cur_y = clamp_axis(cur_y, int'(my), lim_y);
            r.move_x = mx;
            r.move_y = my;
            r.buttons = hdr_q[BUTTON_BITS-1:0];
            r.pos_x = cur_x;
            r.pos_y = cur_y;
            r.left_pressed = hdr_q[0] && !left_q;
            left_q = hdr_q[0];
            produced = 1'b1;
         end
         default: begin
            if (b[HDR_VALID_BIT]) begin
               hdr_q = b;
               frame_phase = WAIT_X;
            end else begin
               dropped_bytes++;
            end
         end
      endcase
      return produced;
   endfunction

   function automatic stim_row_t plain_row(input logic [BYTE_BITS-1:0] b);
      stim_row_t s;
      s.rx_byte = b;
      s.typed = 1'b0;
      s.result = NO_RESULT;
      return s;
   endfunction

   function automatic stim_row_t typed_row(input logic [BYTE_BITS-1:0] b, input int mx,
                                           input int my, input int btn, input int px,
                                           input int py, input int lp);
      stim_row_t s;
      s.rx_byte = b;
      s.typed = 1'b1;
      s.result.move_x = move_type'(mx);
      s.result.move_y = move_type'(my);
      s.result.buttons = BUTTON_BITS'(btn);
      s.result.pos_x = COORD'(px);
      s.result.pos_y = COORD'(py);
      s.result.left_pressed = lp[0];
      return s;
   endfunction

   // called at a rising edge; returns at the edge where the beat was taken or a gap ended
   task automatic send_byte(input logic [BYTE_BITS-1:0] b, input logic typed,
                            input packet_result_t typed_res);
      packet_result_t r;
      bit             has_result;
      req_valid <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
      has_result = track_byte(b, r);
      if (has_result) expected_packets.push_back(typed ? typed_res : r);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end else begin
         burst_left--;
      end
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [LIMIT_BITS-1:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_X_LIMIT) lim_x = data;
      else if (idx == CSR_Y_LIMIT) lim_y = data;
   endtask

   task automatic apply_limits(input logic [LIMIT_BITS-1:0] x_lim,
                               input logic [LIMIT_BITS-1:0] y_lim);
      while (expected_packets.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      write_reg(CSR_SPARE_2, LIMIT_BITS'($urandom));
      write_reg(CSR_SPARE_3, LIMIT_BITS'($urandom));
      write_reg(CSR_X_LIMIT, x_lim);
      write_reg(CSR_Y_LIMIT, y_lim);
      settings_used++;
      @(posedge clock);
   endtask

   task automatic send_random_packet();
      logic [BYTE_BITS-1:0] hdr;
      logic [BYTE_BITS-1:0] xb;
      logic [BYTE_BITS-1:0] yb;
      logic                 xs;
      logic                 ys;
      hdr = BYTE_BITS'($urandom);
      hdr[HDR_VALID_BIT] = 1'b1;
      xb = BYTE_BITS'($urandom);
      yb = BYTE_BITS'($urandom);
      // small moves keep the cursor off the rails for a while
      if ($urandom_range(0, 1) == 1) begin
         xs = 1'($urandom);
         ys = 1'($urandom);
         xb = xs ? BYTE_BITS'($urandom_range(236, 255)) : BYTE_BITS'($urandom_range(0, 20));
         yb = ys ? BYTE_BITS'($urandom_range(236, 255)) : BYTE_BITS'($urandom_range(0, 20));
         hdr[HDR_XSIGN_BIT] = xs;
         hdr[HDR_YSIGN_BIT] = ys;
      end
      send_byte(hdr, 1'b0, NO_RESULT);
      send_byte(xb, 1'b0, NO_RESULT);
      send_byte(yb, 1'b0, NO_RESULT);
   endtask

   // receiver back-pressure, switching between a few patterns
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = stall_mode_t'($urandom_range(0, 2));
            mode_left = $urandom_range(20, 200);
            stall_period = $urandom_range(2, 9);
            stall_duty = $urandom_range(1, stall_period - 1);
            stall_tick = 0;
         end else begin
            mode_left--;
         end
         case (stall_mode)
            STALL_RANDOM:   rsp_stall <= ($urandom_range(0, 2) == 0);
            STALL_PERIODIC: rsp_stall <= (stall_tick < stall_duty);
            default:        rsp_stall <= 1'b0;
         endcase
         stall_tick = (stall_tick + 1) % stall_period;
      end
   end

   // result checker
   always @(posedge clock) begin
      packet_result_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         packets_seen++;
         if (expected_packets.size() == 0) begin
            report_error("result beat with no packet outstanding");
         end else begin
            want = expected_packets.pop_front();
            if (rsp_move_x !== want.move_x)
               report_error($sformatf("move_x got %0d want %0d", rsp_move_x, want.move_x));
            if (rsp_move_y !== want.move_y)
               report_error($sformatf("move_y got %0d want %0d", rsp_move_y, want.move_y));
            if (rsp_button_bits !== want.buttons)
               report_error($sformatf("button_bits got %0d want %0d", rsp_button_bits,
                                      want.buttons));
            if (rsp_pos_x !== want.pos_x)
               report_error($sformatf("pos_x got %0d want %0d", rsp_pos_x, want.pos_x));
            if (rsp_pos_y !== want.pos_y)
               report_error($sformatf("pos_y got %0d want %0d", rsp_pos_y, want.pos_y));
            if (rsp_left_pressed !== want.left_pressed)
               report_error($sformatf("left_pressed got %0d want %0d", rsp_left_pressed,
                                      want.left_pressed));
         end
      end
   end

   // watchdog on cycles with no beat on any port
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [LIMIT_BITS-1:0] nx;
      logic [LIMIT_BITS-1:0] ny;
      int                    counted;
      int                    pick;
      logic [BYTE_BITS-1:0]  noise;

      // header-less bytes, then packets hitting both rails, zero sums and sign bits
      directed_rows.push_back(plain_row(8'h00));
      directed_rows.push_back(plain_row(8'hF7));
      directed_rows.push_back(plain_row(8'h08));
      directed_rows.push_back(plain_row(8'h00));
      directed_rows.push_back(typed_row(8'h00, 0, 0, 0, 160, 120, 0));
      directed_rows.push_back(plain_row(8'h09));
      directed_rows.push_back(plain_row(8'hFF));
      directed_rows.push_back(typed_row(8'hFF, 255, 255, 1, 316, 236, 1));
      directed_rows.push_back(plain_row(8'h3F));
      directed_rows.push_back(plain_row(8'h00));
      directed_rows.push_back(typed_row(8'h00, -256, -256, 7, 60, 0, 0));
      // overflow bits set, they must not matter
      directed_rows.push_back(plain_row(8'hF8));
      directed_rows.push_back(plain_row(8'h00));
      directed_rows.push_back(typed_row(8'h80, -256, -128, 0, 0, 0, 0));
      directed_rows.push_back(plain_row(8'h09));
      directed_rows.push_back(plain_row(8'h01));
      directed_rows.push_back(typed_row(8'h01, 1, 1, 1, 1, 1, 1));
      // sum lands exactly on zero
      directed_rows.push_back(plain_row(8'h38));
      directed_rows.push_back(plain_row(8'hFF));
      directed_rows.push_back(typed_row(8'hFF, -1, -1, 0, 0, 0, 0));
      // y sum lands exactly on the limit
      directed_rows.push_back(plain_row(8'h08));
      directed_rows.push_back(plain_row(8'hFF));
      directed_rows.push_back(typed_row(8'hEC, 255, 236, 0, 255, 236, 0));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_byte(directed_rows[i].rx_byte, directed_rows[i].typed, directed_rows[i].result);
      req_valid <= 1'b0;

      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0:       begin nx = X_LIMIT_RESET;        ny = Y_LIMIT_RESET;        end
            1:       begin nx = '0;                   ny = '0;                   end
            2:       begin nx = LIMIT_BITS'(LIMIT_MAX); ny = LIMIT_BITS'(LIMIT_MAX); end
            3:       begin nx = LIMIT_BITS'(1);       ny = LIMIT_BITS'(LIMIT_MAX); end
            4:       begin nx = LIMIT_BITS'(LIMIT_MAX); ny = '0;                 end
            default: begin
               nx = LIMIT_BITS'($urandom_range(0, LIMIT_MAX));
               ny = LIMIT_BITS'($urandom_range(0, LIMIT_MAX));
            end
         endcase
         apply_limits(nx, ny);
         counted = 0;
         while (counted < ITEMS_PER_PHASE) begin
            pick = $urandom_range(0, 99);
            if (pick < 85) begin
               send_random_packet();
               counted += 3;
            end else if (pick < 95) begin
               // header-less noise, dropped when between packets
               noise = BYTE_BITS'($urandom);
               noise[HDR_VALID_BIT] = 1'b0;
               send_byte(noise, 1'b0, NO_RESULT);
            end else begin
               // stray byte that may knock the framing out of step
               send_byte(BYTE_BITS'($urandom), 1'b0, NO_RESULT);
               counted++;
            end
         end
         req_valid <= 1'b0;
      end

      while (expected_packets.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_packets.size() != 0)
         report_error($sformatf("%0d packets never came out", expected_packets.size()));

      $display("sent %0d bytes (%0d dropped as header-less), checked %0d packets",
               bytes_sent, dropped_bytes, packets_seen);
      $display("limits changed %0d times, both axes taken to 0 and to full scale",
               settings_used);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", error_count);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
